/* hw/rtl/kted_pkg.sv */
// ----------------------------------------------------------------------------
// kted_pkg: shared types and constants for the escape-key decoder
// Decode phase codes, key codes, character codes and the state/result
// structs passed between the top level and the decode logic.
// ----------------------------------------------------------------------------
package kted_pkg;

  localparam int unsigned KEY_W   = 10;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned PHASE_W = 4;

  // Decode phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE    = 4'd0;
  localparam logic [PHASE_W-1:0] PH_ESC     = 4'd1;
  localparam logic [PHASE_W-1:0] PH_SKIP    = 4'd2;
  localparam logic [PHASE_W-1:0] PH_CSI     = 4'd3;
  localparam logic [PHASE_W-1:0] PH_CSI_NUM = 4'd4;
  localparam logic [PHASE_W-1:0] PH_SS3     = 4'd5;
  localparam logic [PHASE_W-1:0] PH_MOUSE_B = 4'd6;
  localparam logic [PHASE_W-1:0] PH_MOUSE_X = 4'd7;
  localparam logic [PHASE_W-1:0] PH_MOUSE_Y = 4'd8;

  // Operation codes
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  // Key codes
  localparam logic [KEY_W-1:0] KEY_BACK_CHAR   = 10'd2;
  localparam logic [KEY_W-1:0] KEY_FWD_CHAR    = 10'd6;
  localparam logic [KEY_W-1:0] KEY_NEXT_LINE   = 10'd14;
  localparam logic [KEY_W-1:0] KEY_PREV_LINE   = 10'd16;
  localparam logic [KEY_W-1:0] KEY_SCROLL_DOWN = 10'd22;
  localparam logic [KEY_W-1:0] KEY_BARE_ESC    = 10'd27;
  localparam logic [KEY_W-1:0] KEY_SCROLL_UP   = 10'd1000;
  localparam logic [KEY_W-1:0] KEY_BUF_START   = 10'd1001;
  localparam logic [KEY_W-1:0] KEY_BUF_END     = 10'd1002;
  localparam logic [KEY_W-1:0] KEY_DEL_FWD     = 10'd1003;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_ESC    = 8'h1b;
  localparam logic [BYTE_W-1:0] CH_V      = 8'h76;
  localparam logic [BYTE_W-1:0] CH_LT     = 8'h3c;
  localparam logic [BYTE_W-1:0] CH_GT     = 8'h3e;
  localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5b;
  localparam logic [BYTE_W-1:0] CH_SS3    = 8'h4f;
  localparam logic [BYTE_W-1:0] CH_A      = 8'h41;
  localparam logic [BYTE_W-1:0] CH_B      = 8'h42;
  localparam logic [BYTE_W-1:0] CH_C      = 8'h43;
  localparam logic [BYTE_W-1:0] CH_D      = 8'h44;
  localparam logic [BYTE_W-1:0] CH_H      = 8'h48;
  localparam logic [BYTE_W-1:0] CH_F      = 8'h46;
  localparam logic [BYTE_W-1:0] CH_M      = 8'h4d;
  localparam logic [BYTE_W-1:0] CH_TILDE  = 8'h7e;
  localparam logic [BYTE_W-1:0] CH_DIG0   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_DIG1   = 8'h31;
  localparam logic [BYTE_W-1:0] CH_DIG3   = 8'h33;
  localparam logic [BYTE_W-1:0] CH_DIG4   = 8'h34;
  localparam logic [BYTE_W-1:0] CH_DIG5   = 8'h35;
  localparam logic [BYTE_W-1:0] CH_DIG6   = 8'h36;
  localparam logic [BYTE_W-1:0] CH_DIG7   = 8'h37;
  localparam logic [BYTE_W-1:0] CH_DIG8   = 8'h38;
  localparam logic [BYTE_W-1:0] CH_DIG9   = 8'h39;

  // Mouse wheel button codes
  localparam logic [BYTE_W-1:0] WHEEL_UP_CODE   = 8'd96;
  localparam logic [BYTE_W-1:0] WHEEL_DOWN_CODE = 8'd97;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [BYTE_W-1:0]  held_digit;
    logic [BYTE_W-1:0]  wheel_button;
  } kted_state_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] code;
  } kted_result_t;

endpackage

/* hw/rtl/kted_decoder.sv */
// ----------------------------------------------------------------------------
// kted_decoder: one-step escape sequence decode
// Given the current decode state and one transaction, produce the next
// state and at most one key code.
// ----------------------------------------------------------------------------
module kted_decoder (
  input  logic                           operation,
  input  logic [kted_pkg::BYTE_W-1:0]    data_byte,
  input  kted_pkg::kted_state_t          state_cur,
  output kted_pkg::kted_state_t          state_nxt,
  output kted_pkg::kted_result_t         result
);
  import kted_pkg::*;

  logic [PHASE_W-1:0] phase;
  logic               timeout;
  logic               is_digit;

  assign timeout  = (operation == OP_TIMEOUT);
  assign is_digit = (data_byte >= CH_DIG0) && (data_byte <= CH_DIG9);
  // Fold unused phase codes onto idle
  assign phase    = (state_cur.phase > PH_MOUSE_Y) ? PH_IDLE : state_cur.phase;

  always_comb begin
    state_nxt       = state_cur;
    state_nxt.phase = phase;
    result.valid    = 1'b0;
    result.code     = KEY_BARE_ESC;

    if (phase == PH_IDLE) begin
      if (!timeout) begin
        if (data_byte == CH_ESC) begin
          state_nxt.phase = PH_ESC;
        end else begin
          result.valid = 1'b1;
          result.code  = {2'b00, data_byte};
        end
      end
    end else if (timeout) begin
      result.valid    = 1'b1;
      result.code     = KEY_BARE_ESC;
      state_nxt.phase = PH_IDLE;
    end else begin
      case (phase)
        PH_ESC: begin
          if (data_byte == CH_V) begin
            result.valid = 1'b1;
            result.code  = KEY_SCROLL_UP;
          end else if (data_byte == CH_LT) begin
            result.valid = 1'b1;
            result.code  = KEY_BUF_START;
          end else if (data_byte == CH_GT) begin
            result.valid = 1'b1;
            result.code  = KEY_BUF_END;
          end else if (data_byte == CH_LBRACK) begin
            state_nxt.phase = PH_CSI;
          end else if (data_byte == CH_SS3) begin
            state_nxt.phase = PH_SS3;
          end else begin
            state_nxt.phase = PH_SKIP;
          end
        end
        PH_SKIP: begin
          result.valid = 1'b1;
          result.code  = KEY_BARE_ESC;
        end
        PH_CSI: begin
          if (is_digit) begin
            state_nxt.held_digit = data_byte;
            state_nxt.phase      = PH_CSI_NUM;
          end else if (data_byte == CH_M) begin
            state_nxt.phase = PH_MOUSE_B;
          end else begin
            result.valid = 1'b1;
            case (data_byte)
              CH_A:    result.code = KEY_PREV_LINE;
              CH_B:    result.code = KEY_NEXT_LINE;
              CH_C:    result.code = KEY_FWD_CHAR;
              CH_D:    result.code = KEY_BACK_CHAR;
              CH_H:    result.code = KEY_BUF_START;
              CH_F:    result.code = KEY_BUF_END;
              default: result.code = KEY_BARE_ESC;
            endcase
          end
        end
        PH_CSI_NUM: begin
          result.valid = 1'b1;
          if (data_byte != CH_TILDE) begin
            result.code = KEY_BARE_ESC;
          end else begin
            case (state_cur.held_digit)
              CH_DIG5:          result.code = KEY_SCROLL_UP;
              CH_DIG6:          result.code = KEY_SCROLL_DOWN;
              CH_DIG1, CH_DIG7: result.code = KEY_BUF_START;
              CH_DIG4, CH_DIG8: result.code = KEY_BUF_END;
              CH_DIG3:          result.code = KEY_DEL_FWD;
              default:          result.code = KEY_BARE_ESC;
            endcase
          end
        end
        PH_SS3: begin
          result.valid = 1'b1;
          if (data_byte == CH_H) begin
            result.code = KEY_BUF_START;
          end else if (data_byte == CH_F) begin
            result.code = KEY_BUF_END;
          end else begin
            result.code = KEY_BARE_ESC;
          end
        end
        PH_MOUSE_B: begin
          state_nxt.wheel_button = data_byte;
          state_nxt.phase        = PH_MOUSE_X;
        end
        PH_MOUSE_X: begin
          state_nxt.phase = PH_MOUSE_Y;
        end
        PH_MOUSE_Y: begin
          result.valid = 1'b1;
          if (state_cur.wheel_button == WHEEL_UP_CODE) begin
            result.code = KEY_PREV_LINE;
          end else if (state_cur.wheel_button == WHEEL_DOWN_CODE) begin
            result.code = KEY_NEXT_LINE;
          end else begin
            result.code = KEY_BARE_ESC;
          end
        end
        default: begin
          state_nxt.phase = PH_IDLE;
        end
      endcase
      // Any emitted key closes the sequence
      if (result.valid) begin
        state_nxt.phase = PH_IDLE;
      end
    end
  end

endmodule

/* hw/rtl/terminal_escape_key_decoder_unit.sv */
// ----------------------------------------------------------------------------
// terminal_escape_key_decoder_unit: terminal byte stream to editor key codes
// Path: input transaction to key code on out_ through the input register,
//   then decode into the result register.
// Throughput: 1 transaction per cycle while the result channel is not
//   stalled, set by the decode step that updates the sequence state; a stalled
//   result holds the input register, which then stalls the input channel.
// Reset: synchronous active-low rst_n empties both stages and returns the
//   decoder to idle with held digit and wheel button cleared.
// ----------------------------------------------------------------------------
module terminal_escape_key_decoder_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_operation,
  input  logic [kted_pkg::BYTE_W-1:0]  in_data_byte,
  // Result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [kted_pkg::KEY_W-1:0]   out_key_code
);
  import kted_pkg::*;

  // Input register stage
  logic                s1_valid_r;
  logic                s1_valid_nxt;
  logic                s1_op_r;
  logic [BYTE_W-1:0]   s1_byte_r;

  // Result register stage
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [KEY_W-1:0]    out_code_r;

  // Decode state
  kted_state_t         st_r;
  kted_state_t         st_nxt;
  kted_result_t        dec_res;

  logic                out_free;
  logic                s1_fire;
  logic                in_fire;

  // The result register can take a new key when empty or being drained
  assign out_free = !out_valid_r || !out_stall;
  // Advance the input stage only when the result register has room
  assign s1_fire  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_fire  = in_valid && !in_stall;

  kted_decoder u_decoder (
    .operation (s1_op_r),
    .data_byte (s1_byte_r),
    .state_cur (st_r),
    .state_nxt (st_nxt),
    .result    (dec_res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = dec_res.valid;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '{phase: PH_IDLE, held_digit: '0, wheel_button: '0};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      // Hold the sequence state until the buffered transaction is decoded
      if (s1_fire) begin
        st_r <= st_nxt;
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r   <= in_operation;
      s1_byte_r <= in_data_byte;
    end
    if (s1_fire && dec_res.valid) begin
      out_code_r <= dec_res.code;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_key_code = out_code_r;

endmodule

/* hw/rtl/kted_checker.sv */
// ----------------------------------------------------------------------------
// kted_checker: port-level checks for the escape-key decoder
// Watches the top-level ports and is attached by a bind statement.
// ----------------------------------------------------------------------------
module kted_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [kted_pkg::KEY_W-1:0]   out_key_code
);
  import kted_pkg::*;

  // Input backpressure only arises from a held result
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled key code does not change
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_key_code))
    else $error("key code changed while stalled");

  // Key codes are bytes or control codes, never in between
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_key_code < KEY_W'(256)) ||
                   ((out_key_code >= KEY_SCROLL_UP) && (out_key_code <= KEY_DEL_FWD))))
    else $error("key code out of range");

  // Right after reset no result is offered
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind terminal_escape_key_decoder_unit kted_checker u_kted_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_key_code (out_key_code)
);
